// ===== design/tcce_pkg.sv =====
// ----------------------------------------------------------------------------
// Text console cell engine package
// Shared types, operation codes, character codes and defaults.
// ----------------------------------------------------------------------------
package tcce_pkg;

	// Default screen geometry.
	localparam int COLS_DEF      = 80;
	localparam int ROWS_DEF      = 25;
	localparam int TAB_WIDTH_DEF = 8;

	// Field widths of the beats on both channels.
	localparam int OP_W   = 3;
	localparam int BYTE_W = 8;
	localparam int CCOL_W = 7;
	localparam int CROW_W = 5;
	localparam int CPOS_W = 11;
	localparam int CELL_W = 16;

	// Configuration port.
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 4;
	localparam logic [CFG_IDX_W-1:0] CFG_FG = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_BG = 1'b1;
	localparam logic [3:0] RESET_FG = 4'h7;
	localparam logic [3:0] RESET_BG = 4'h0;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_PUT   = 3'd0;
	localparam logic [OP_W-1:0] OP_MOVE  = 3'd1;
	localparam logic [OP_W-1:0] OP_CLEAR = 3'd2;
	localparam logic [OP_W-1:0] OP_ATTR  = 3'd3;
	localparam logic [OP_W-1:0] OP_READ  = 3'd4;

	// Character codes.
	localparam logic [BYTE_W-1:0] CH_BS       = 8'h08;
	localparam logic [BYTE_W-1:0] CH_TAB      = 8'h09;
	localparam logic [BYTE_W-1:0] CH_LF       = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_CR       = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_BLANK    = 8'h20;
	localparam logic [BYTE_W-1:0] CH_PRINT_LO = 8'h20;
	localparam logic [BYTE_W-1:0] CH_PRINT_HI = 8'h7F;

	localparam logic [CELL_W-1:0] RESET_BLANK = {RESET_BG, RESET_FG, CH_BLANK};

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_RMW,
		S_TAB,
		S_SCROLL,
		S_SBLANK,
		S_CLEAR,
		S_RESP
	} state_t;

endpackage

// ===== design/tcce_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tcce_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== design/text_console_cell_engine_top.sv =====
// ----------------------------------------------------------------------------
// Text console cell engine
// Screen of attribute/character cells with a cursor, kept in one RAM.
// ----------------------------------------------------------------------------
// After reset the block sweeps the screen RAM to blank cells, one cell per
// cycle, and accepts no beat until the sweep is done. Every accepted beat gives
// one result beat. Set attribute and read cell on the screen pass through a
// read-modify-write state because the RAM read data is registered; a tab
// writes one blank per column it passes. A clear blanks and a scroll moves
// and blanks one cell per cycle, since the single write port of the screen
// RAM handles one cell at a time.
// A result waiting in the output register holds off the next one.
module text_console_cell_engine_top #(
	parameter int COLS      = tcce_pkg::COLS_DEF,
	parameter int ROWS      = tcce_pkg::ROWS_DEF,
	parameter int TAB_WIDTH = tcce_pkg::TAB_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [tcce_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tcce_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [tcce_pkg::OP_W-1:0]       operation,
	input  logic [tcce_pkg::BYTE_W-1:0]     char_code,
	input  logic [tcce_pkg::BYTE_W-1:0]     col,
	input  logic [tcce_pkg::BYTE_W-1:0]     row,
	input  logic [tcce_pkg::BYTE_W-1:0]     attr,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [tcce_pkg::CCOL_W-1:0]     cur_col,
	output logic [tcce_pkg::CROW_W-1:0]     cur_row,
	output logic [tcce_pkg::CPOS_W-1:0]     cursor_pos,
	output logic [tcce_pkg::CELL_W-1:0]     cell_value
);

	import tcce_pkg::*;

	localparam int CELLS = COLS * ROWS;
	localparam int AW    = $clog2(CELLS);
	localparam int XI    = $clog2(COLS);
	localparam int YW    = $clog2(ROWS);
	localparam logic [AW-1:0] CNT_LAST  = AW'(CELLS - 1);
	localparam logic [AW-1:0] COPY_LAST = AW'(CELLS - COLS - 1);

	state_t state_q, state_d;

	logic [3:0]        fg_color_q, bg_color_q;
	logic [XI-1:0]     cur_x_q;
	logic [YW-1:0]     cur_y_q;
	logic [AW-1:0]     cnt_q;
	logic              pipe_v_s1;
	logic [AW-1:0]     pipe_a_s1;
	logic [OP_W-1:0]   op_q;
	logic [BYTE_W-1:0] attr_q;
	logic [AW-1:0]     idx_q;
	logic [CELL_W-1:0] cell_q;
	logic [XI-1:0]     tab_tgt_q;
	logic              out_valid_q;
	logic [CCOL_W-1:0] cur_col_q;
	logic [CROW_W-1:0] cur_row_q;
	logic [CPOS_W-1:0] cursor_pos_q;
	logic [CELL_W-1:0] cell_value_q;

	logic              mem_we;
	logic [AW-1:0]     mem_waddr, mem_raddr;
	logic [CELL_W-1:0] mem_wdata, mem_rdata;

	logic              acc, out_load;
	logic [BYTE_W-1:0] cur_attr;
	logic [CELL_W-1:0] blank;
	logic [AW-1:0]     cur_addr, in_idx;
	logic              in_range, x_nz, x_last, y_last, tab_done;
	logic              put_lf, put_cr, put_tab, put_bs, put_prn, need_scroll;
	logic [XI-1:0]     tab_stop [COLS];
	logic [XI-1:0]     tab_tgt;

	// Next tab stop for each column, capped at the last column.
	for (genvar g = 0; g < COLS; g++) begin : g_tab
		localparam int Nxt = ((g / TAB_WIDTH) + 1) * TAB_WIDTH;
		assign tab_stop[g] = XI'((Nxt >= COLS) ? (COLS - 1) : Nxt);
	end

	assign cur_attr = {bg_color_q, fg_color_q};
	assign blank    = {cur_attr, CH_BLANK};
	assign cur_addr = AW'(cur_y_q) * AW'(COLS) + AW'(cur_x_q);
	assign in_idx   = AW'(row) * AW'(COLS) + AW'(col);
	assign in_range = (col < 8'(COLS)) && (row < 8'(ROWS));
	assign x_nz     = cur_x_q != '0;
	assign x_last   = cur_x_q == XI'(COLS - 1);
	assign y_last   = cur_y_q == YW'(ROWS - 1);
	assign tab_tgt  = tab_stop[cur_x_q];
	assign tab_done = (cur_x_q + 1'b1) == tab_tgt_q;

	assign put_lf  = char_code == CH_LF;
	assign put_cr  = char_code == CH_CR;
	assign put_tab = char_code == CH_TAB;
	assign put_bs  = char_code == CH_BS;
	assign put_prn = (char_code >= CH_PRINT_LO) && (char_code <= CH_PRINT_HI);
	// A new row past the bottom one scrolls; the cursor then stays on the bottom row.
	assign need_scroll = y_last && (put_lf || (put_prn && x_last));

	assign acc = in_valid && in_ready;

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		out_load  = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = cur_addr;
		mem_wdata = blank;
		mem_raddr = in_idx;
		unique case (state_q)
			S_INIT: begin
				mem_we    = 1'b1;
				mem_waddr = cnt_q;
				mem_wdata = RESET_BLANK;
				if (cnt_q == CNT_LAST) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					unique case (operation)
						OP_PUT: begin
							if (put_bs && x_nz) begin
								mem_we    = 1'b1;
								mem_waddr = cur_addr - AW'(1);
							end else if (put_prn) begin
								mem_we    = 1'b1;
								mem_wdata = {cur_attr, char_code};
							end
							if (need_scroll) begin
								state_d = S_SCROLL;
							end else if (put_tab && (cur_x_q < tab_tgt)) begin
								state_d = S_TAB;
							end else begin
								state_d = S_RESP;
							end
						end
						OP_CLEAR: state_d = S_CLEAR;
						OP_ATTR, OP_READ: state_d = in_range ? S_RMW : S_RESP;
						default: state_d = S_RESP;
					endcase
				end
			end
			S_RMW: begin
				if (op_q == OP_ATTR) begin
					mem_we    = 1'b1;
					mem_waddr = idx_q;
					mem_wdata = {attr_q, mem_rdata[BYTE_W-1:0]};
				end
				state_d = S_RESP;
			end
			S_TAB: begin
				mem_we = 1'b1;
				if (tab_done) begin
					state_d = S_RESP;
				end
			end
			S_SCROLL: begin
				// Read one row ahead; the write of each cell follows in the cycle after its read.
				mem_raddr = cnt_q + AW'(COLS);
				if (pipe_v_s1) begin
					mem_we    = 1'b1;
					mem_waddr = pipe_a_s1;
					mem_wdata = mem_rdata;
				end
				if (cnt_q == COPY_LAST) begin
					state_d = S_SBLANK;
				end
			end
			S_SBLANK: begin
				mem_we = 1'b1;
				if (pipe_v_s1) begin
					mem_waddr = pipe_a_s1;
					mem_wdata = mem_rdata;
				end else begin
					mem_waddr = cnt_q;
					if (cnt_q == CNT_LAST) begin
						state_d = S_RESP;
					end
				end
			end
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = cnt_q;
				if (cnt_q == CNT_LAST) begin
					state_d = S_RESP;
				end
			end
			S_RESP: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_color_q  <= RESET_FG;
			bg_color_q  <= RESET_BG;
			cur_x_q     <= '0;
			cur_y_q     <= '0;
			cnt_q       <= '0;
			pipe_v_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_FG: fg_color_q <= cfg_data;
					CFG_BG: bg_color_q <= cfg_data;
				endcase
			end

			pipe_v_s1 <= state_q == S_SCROLL;

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (acc) begin
				unique case (operation)
					OP_PUT: begin
						if (put_lf) begin
							cur_x_q <= '0;
							if (!y_last) begin
								cur_y_q <= cur_y_q + 1'b1;
							end
						end else if (put_cr) begin
							cur_x_q <= '0;
						end else if (put_bs && x_nz) begin
							cur_x_q <= cur_x_q - 1'b1;
						end else if (put_prn) begin
							if (x_last) begin
								cur_x_q <= '0;
								if (!y_last) begin
									cur_y_q <= cur_y_q + 1'b1;
								end
							end else begin
								cur_x_q <= cur_x_q + 1'b1;
							end
						end
						if (need_scroll) begin
							cnt_q <= '0;
						end
					end
					OP_MOVE: begin
						if (in_range) begin
							cur_x_q <= XI'(col);
							cur_y_q <= YW'(row);
						end
					end
					OP_CLEAR: begin
						cur_x_q <= '0;
						cur_y_q <= '0;
						cnt_q   <= '0;
					end
					default: begin
					end
				endcase
			end

			unique case (state_q)
				S_INIT, S_CLEAR, S_SCROLL: cnt_q <= cnt_q + 1'b1;
				S_SBLANK: begin
					if (!pipe_v_s1) begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_TAB: cur_x_q <= cur_x_q + 1'b1;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		pipe_a_s1 <= cnt_q;
		if (acc) begin
			op_q      <= operation;
			attr_q    <= attr;
			idx_q     <= in_idx;
			cell_q    <= '0;
			tab_tgt_q <= tab_tgt;
		end
		if (state_q == S_RMW && op_q == OP_READ) begin
			cell_q <= mem_rdata;
		end
		if (out_load) begin
			cur_col_q    <= CCOL_W'(cur_x_q);
			cur_row_q    <= CROW_W'(cur_y_q);
			cursor_pos_q <= CPOS_W'(cur_addr);
			cell_value_q <= cell_q;
		end
	end

	tcce_ram #(
		.WIDTH(CELL_W),
		.DEPTH(CELLS)
	) u_screen (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	assign out_valid  = out_valid_q;
	assign cur_col    = cur_col_q;
	assign cur_row    = cur_row_q;
	assign cursor_pos = cursor_pos_q;
	assign cell_value = cell_value_q;

	a_cursor_on_screen: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> (32'(cur_x_q) < COLS) && (32'(cur_y_q) < ROWS))
		else $error("cursor left the screen");

	a_copy_in_scroll: assert property (@(posedge clk) disable iff (!arst_n)
		pipe_v_s1 |-> (state_q == S_SCROLL) || (state_q == S_SBLANK))
		else $error("row copy write outside a scroll");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> !in_ready)
		else $error("second beat taken before the result");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RESP) && (!out_valid_q || out_ready) |=> out_valid_q)
		else $error("finished result not presented");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> 32'(mem_waddr) < CELLS)
		else $error("screen write beyond the last cell");

endmodule

// ===== dv/text_console_cell_engine_checker.sv =====
// ----------------------------------------------------------------------------
// Text console cell engine checker
// Follows the register port and both beat channels of the console, keeps its
// own copy of the screen, the cursor and the colors, and compares every
// result beat field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
module text_console_cell_engine_checker #(
	parameter int COLS      = tcce_pkg::COLS_DEF,
	parameter int ROWS      = tcce_pkg::ROWS_DEF,
	parameter int TAB_WIDTH = tcce_pkg::TAB_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [tcce_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tcce_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	input  logic                            in_ready,
	input  logic [tcce_pkg::OP_W-1:0]       operation,
	input  logic [tcce_pkg::BYTE_W-1:0]     char_code,
	input  logic [tcce_pkg::BYTE_W-1:0]     col,
	input  logic [tcce_pkg::BYTE_W-1:0]     row,
	input  logic [tcce_pkg::BYTE_W-1:0]     attr,
	input  logic                            out_valid,
	input  logic                            out_ready,
	input  logic [tcce_pkg::CCOL_W-1:0]     cur_col,
	input  logic [tcce_pkg::CROW_W-1:0]     cur_row,
	input  logic [tcce_pkg::CPOS_W-1:0]     cursor_pos,
	input  logic [tcce_pkg::CELL_W-1:0]     cell_value,
	output int                              mismatches,
	output int                              in_flight
);

	import tcce_pkg::*;

	localparam int CELLS = COLS * ROWS;

	typedef struct packed {
		logic [CCOL_W-1:0] ccol;
		logic [CROW_W-1:0] crow;
		logic [CPOS_W-1:0] cpos;
		logic [CELL_W-1:0] cval;
	} console_result_t;

	logic [CELL_W-1:0] screen [CELLS];
	int                cur_x;
	int                cur_y;
	logic [3:0]        fg_color;
	logic [3:0]        bg_color;
	console_result_t   predicted_results [$];
	console_result_t   predicted;
	console_result_t   oldest;
	int                fail_count;

	function automatic logic [CELL_W-1:0] blank_cell();
		return {bg_color, fg_color, CH_BLANK};
	endfunction

	task automatic write_at_cursor(input logic [CELL_W-1:0] value);
		int idx;
		idx = cur_y * COLS + cur_x;
		if (idx < CELLS) begin
			screen[idx] = value;
		end
	endtask

	task automatic clear_screen();
		for (int i = 0; i < CELLS; i++) begin
			screen[i] = blank_cell();
		end
		cur_x = 0;
		cur_y = 0;
	endtask

	task automatic scroll_screen();
		for (int i = 0; i + COLS < CELLS; i++) begin
			screen[i] = screen[i + COLS];
		end
		for (int i = CELLS - COLS; i < CELLS; i++) begin
			screen[i] = blank_cell();
		end
		if (cur_y > 0) begin
			cur_y--;
		end
	endtask

	task automatic put_char(input logic [BYTE_W-1:0] c);
		int stop;
		if (c == CH_LF) begin
			cur_x = 0;
			cur_y++;
		end else if (c == CH_CR) begin
			cur_x = 0;
		end else if (c == CH_TAB) begin
			// Next tab stop strictly right of the cursor, never past the last column.
			stop = ((cur_x + TAB_WIDTH) / TAB_WIDTH) * TAB_WIDTH;
			if (stop >= COLS) begin
				stop = COLS - 1;
			end
			while (cur_x < stop) begin
				write_at_cursor(blank_cell());
				cur_x++;
			end
		end else if (c == CH_BS) begin
			if (cur_x > 0) begin
				cur_x--;
				write_at_cursor(blank_cell());
			end
		end else if (c >= CH_PRINT_LO && c <= CH_PRINT_HI) begin
			write_at_cursor({bg_color, fg_color, c});
			cur_x++;
		end
		if (cur_x >= COLS) begin
			cur_x = 0;
			cur_y++;
		end
		while (cur_y >= ROWS) begin
			scroll_screen();
		end
	endtask

	task automatic run_command(
		input  logic [OP_W-1:0]   op,
		input  logic [BYTE_W-1:0] ch,
		input  logic [BYTE_W-1:0] tcol,
		input  logic [BYTE_W-1:0] trow,
		input  logic [BYTE_W-1:0] new_attr,
		output console_result_t   res
	);
		logic [CELL_W-1:0] cell_word;
		bit                on_screen;
		int                idx;
		cell_word = '0;
		on_screen = int'(tcol) < COLS && int'(trow) < ROWS;
		idx       = int'(trow) * COLS + int'(tcol);
		case (op)
			OP_PUT: put_char(ch);
			OP_MOVE: begin
				if (on_screen) begin
					cur_x = tcol;
					cur_y = trow;
				end
			end
			OP_CLEAR: clear_screen();
			OP_ATTR: begin
				if (on_screen && idx < CELLS) begin
					screen[idx] = {new_attr, screen[idx][BYTE_W-1:0]};
				end
			end
			OP_READ: begin
				if (on_screen && idx < CELLS) begin
					cell_word = screen[idx];
				end
			end
			default: ;
		endcase
		res.ccol = CCOL_W'(cur_x);
		res.crow = CROW_W'(cur_y);
		res.cpos = CPOS_W'(cur_y * COLS + cur_x);
		res.cval = cell_word;
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch: expected %0d (0x%0h), actual %0d (0x%0h)",
				$time, name, want, want, got, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_color = RESET_FG;
			bg_color = RESET_BG;
			clear_screen();
			predicted_results.delete();
			fail_count = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_FG: fg_color = cfg_data;
					CFG_BG: bg_color = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				run_command(operation, char_code, col, row, attr, predicted);
				predicted_results.push_back(predicted);
			end
			if (out_valid && out_ready) begin
				if (predicted_results.size() == 0) begin
					$display("%0t: result beat with nothing expected: col %0d row %0d pos %0d cell 0x%0h",
						$time, cur_col, cur_row, cursor_pos, cell_value);
					fail_count++;
				end else begin
					oldest = predicted_results.pop_front();
					check_field("cur_col", oldest.ccol, cur_col);
					check_field("cur_row", oldest.crow, cur_row);
					check_field("cursor_pos", oldest.cpos, cursor_pos);
					check_field("cell_value", oldest.cval, cell_value);
				end
			end
		end
		mismatches <= fail_count;
		in_flight  <= predicted_results.size();
	end

endmodule

// ===== dv/tb_text_console_cell_engine_top.sv =====
// ----------------------------------------------------------------------------
// Text console cell engine testbench
// Drives a directed opening and four phases of random console commands with
// different color settings and handshake pressure; the checker beside the
// block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_text_console_cell_engine_top;
	import tcce_pkg::*;

	localparam int               ITEMS_PER_PHASE = 350;
	localparam int               PHASES          = 4;
	localparam int               WATCHDOG_LIMIT  = 20000;
	localparam logic [OP_W-1:0]  OP_SPARE_LO     = 3'd5;
	localparam logic [OP_W-1:0]  OP_SPARE_HI     = 3'd7;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_FG;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	logic [OP_W-1:0]       operation = OP_PUT;
	logic [BYTE_W-1:0]     char_code = '0;
	logic [BYTE_W-1:0]     col       = '0;
	logic [BYTE_W-1:0]     row       = '0;
	logic [BYTE_W-1:0]     attr      = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [CCOL_W-1:0]     cur_col;
	logic [CROW_W-1:0]     cur_row;
	logic [CPOS_W-1:0]     cursor_pos;
	logic [CELL_W-1:0]     cell_value;

	int                    mismatches;
	int                    in_flight;
	int                    send_idle   = 0;
	int                    stall_pct   = 0;
	int                    quiet_cycles = 0;
	logic [CROW_W-1:0]     last_row    = '0;

	text_console_cell_engine_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.operation  (operation),
		.char_code  (char_code),
		.col        (col),
		.row        (row),
		.attr       (attr),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.cur_col    (cur_col),
		.cur_row    (cur_row),
		.cursor_pos (cursor_pos),
		.cell_value (cell_value)
	);

	text_console_cell_engine_checker console_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.operation  (operation),
		.char_code  (char_code),
		.col        (col),
		.row        (row),
		.attr       (attr),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.cur_col    (cur_col),
		.cur_row    (cur_row),
		.cursor_pos (cursor_pos),
		.cell_value (cell_value),
		.mismatches (mismatches),
		.in_flight  (in_flight)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// Reads and attribute writes aim half of the time at the rows the cursor has just
	// filled, so they hit cells that hold real text.
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			last_row <= cur_row;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	task automatic send_command(
		input logic [OP_W-1:0]   op,
		input logic [BYTE_W-1:0] ch,
		input logic [BYTE_W-1:0] tcol,
		input logic [BYTE_W-1:0] trow,
		input logic [BYTE_W-1:0] new_attr
	);
		if (send_idle > 0 && $urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle);
		end
		in_valid  <= 1'b1;
		operation <= op;
		char_code <= ch;
		col       <= tcol;
		row       <= trow;
		attr      <= new_attr;
		do @(posedge clk); while (!in_ready);
	endtask

	// Waits until every result beat is back and the block has settled.
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (in_flight != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_colors(input logic [3:0] fg, input logic [3:0] bg);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_FG;
		cfg_data  <= fg;
		@(posedge clk);
		cfg_index <= CFG_BG;
		cfg_data  <= bg;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	function automatic logic [BYTE_W-1:0] pick_char_code();
		int pick;
		pick = $urandom_range(99);
		if (pick < 70) return BYTE_W'($urandom_range(CH_PRINT_HI, CH_PRINT_LO));
		if (pick < 76) return CH_LF;
		if (pick < 80) return CH_CR;
		if (pick < 86) return CH_TAB;
		if (pick < 92) return CH_BS;
		return BYTE_W'($urandom);
	endfunction

	task automatic pick_target(output logic [BYTE_W-1:0] tcol, output logic [BYTE_W-1:0] trow);
		int pick;
		pick = $urandom_range(99);
		tcol = BYTE_W'($urandom_range(COLS_DEF - 1));
		trow = BYTE_W'($urandom_range(ROWS_DEF - 1));
		if (pick < 50) begin
			trow = (last_row > 0 && $urandom_range(1) == 1) ? BYTE_W'(last_row - 1)
				: BYTE_W'(last_row);
		end else if (pick >= 96) begin
			tcol = BYTE_W'($urandom);
			trow = BYTE_W'($urandom);
		end else if (pick >= 88) begin
			trow = BYTE_W'($urandom_range(255, ROWS_DEF));
		end else if (pick >= 80) begin
			tcol = BYTE_W'($urandom_range(255, COLS_DEF));
		end
	endtask

	task automatic send_random_command();
		int                pick;
		logic [OP_W-1:0]   op;
		logic [BYTE_W-1:0] ch;
		logic [BYTE_W-1:0] tcol;
		logic [BYTE_W-1:0] trow;
		logic [BYTE_W-1:0] new_attr;
		pick     = $urandom_range(99);
		ch       = BYTE_W'($urandom);
		new_attr = BYTE_W'($urandom);
		pick_target(tcol, trow);
		if (pick < 55) begin
			op = OP_PUT;
			ch = pick_char_code();
		end else if (pick < 68) begin
			op = OP_MOVE;
		end else if (pick < 76) begin
			op = OP_ATTR;
		end else if (pick < 94) begin
			op = OP_READ;
		end else if (pick < 95) begin
			op = OP_CLEAR;
		end else begin
			op = OP_W'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
		end
		send_command(op, ch, tcol, trow, new_attr);
	endtask

	initial begin
		int phase_idle [PHASES] = '{0, 81, 0, 38};
		int phase_stall [PHASES] = '{0, 0, 81, 38};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed opening with the reset colors.
		send_command(OP_READ, 8'h00, 8'd0, 8'd0, 8'h00);
		send_command(OP_PUT, 8'h41, 8'd0, 8'd0, 8'h00);
		send_command(OP_PUT, CH_PRINT_LO, 8'd0, 8'd0, 8'h00);
		send_command(OP_PUT, CH_PRINT_HI, 8'd0, 8'd0, 8'h00);
		send_command(OP_PUT, 8'h00, 8'd0, 8'd0, 8'h00);
		send_command(OP_PUT, 8'hFF, 8'd0, 8'd0, 8'h00);
		send_command(OP_PUT, CH_TAB, 8'd0, 8'd0, 8'h00);
		send_command(OP_PUT, CH_BS, 8'd0, 8'd0, 8'h00);
		send_command(OP_PUT, CH_CR, 8'd0, 8'd0, 8'h00);
		send_command(OP_PUT, CH_LF, 8'd0, 8'd0, 8'h00);
		// A tab in the last column does nothing; the next character wraps.
		send_command(OP_MOVE, 8'h00, 8'd79, 8'd0, 8'h00);
		send_command(OP_PUT, CH_TAB, 8'd0, 8'd0, 8'h00);
		send_command(OP_PUT, 8'h5A, 8'd0, 8'd0, 8'h00);
		// Wrapping off the bottom corner scrolls, and so does a newline there.
		send_command(OP_MOVE, 8'h00, 8'd79, 8'd24, 8'h00);
		send_command(OP_PUT, 8'h78, 8'd0, 8'd0, 8'h00);
		send_command(OP_PUT, CH_LF, 8'd0, 8'd0, 8'h00);
		send_command(OP_MOVE, 8'h00, 8'd80, 8'd0, 8'h00);
		send_command(OP_MOVE, 8'h00, 8'd255, 8'd255, 8'h00);
		send_command(OP_ATTR, 8'h00, 8'd0, 8'd23, 8'hFF);
		send_command(OP_ATTR, 8'h00, 8'd80, 8'd24, 8'h00);
		send_command(OP_READ, 8'h00, 8'd0, 8'd23, 8'h00);
		send_command(OP_READ, 8'h00, 8'd255, 8'd255, 8'h00);
		send_command(OP_SPARE_HI, 8'h00, 8'd0, 8'd0, 8'h00);
		send_command(OP_CLEAR, 8'h00, 8'd0, 8'd0, 8'h00);
		send_command(OP_PUT, CH_BS, 8'd0, 8'd0, 8'h00);

		for (int phase = 0; phase < PHASES; phase++) begin
			if (phase > 0) begin
				wait_idle();
				case (phase)
					1: write_colors(4'hF, 4'hF);
					2: write_colors(4'h0, 4'h0);
					default: write_colors(4'($urandom), 4'($urandom));
				endcase
			end
			send_idle = phase_idle[phase];
			stall_pct = phase_stall[phase];
			repeat (ITEMS_PER_PHASE) send_random_command();
		end

		wait_idle();
		repeat (10) @(posedge clk);
		if (mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
